@@ design/alg_pkg.sv @@
// ----------------------------------------------------------------------------
// alg_pkg
// Types, constants and helper functions shared by the Legendre recurrence unit.
// ----------------------------------------------------------------------------
package alg_pkg;

  localparam int FRAC_BITS    = 40;
  localparam int MAX_POINTS   = 64;
  localparam int TAYLOR_TERMS = 15;

  localparam logic [63:0] ONE         = 64'd1 << FRAC_BITS;
  localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ANGLE_K     = PI_HALF_Q62 >> (62 - FRAC_BITS);
  localparam logic [63:0] VAL_MAX     = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] VAL_MIN     = 64'h8000000000000000;

  typedef struct packed {
    logic [5:0] order_m;
    logic [5:0] grid_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         degree;
    logic signed [63:0] value;
    logic               last;
    logic               overflow;
    logic               bad_request;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_CLR, OP_MOV, OP_LDANG, OP_CLAMP, OP_SUB, OP_MULI, OP_MULQ, OP_DIV, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    SEL_ZERO, SEL_ONE, SEL_X, SEL_X2, SEL_T, SEL_SUM, SEL_S, SEL_NS, SEL_C,
    SEL_P0, SEL_P1, SEL_A1, SEL_A2
  } sel_t;

  typedef struct packed {
    logic       go;
    op_t        op;
    sel_t       src_a;
    sel_t       src_b;
    sel_t       dst;
    logic [9:0] k;
    logic       track;
    logic [5:0] degree;
    logic       last;
    logic       bad;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] value;
  } sm_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BAD, ST_CLR, ST_ANG_MUL, ST_ANG_DIV, ST_X2, ST_TINIT, ST_SINIT,
    ST_TMUL, ST_TDIV, ST_TNEG, ST_TSUM, ST_TCLAMP, ST_NEG, ST_P0INIT, ST_P0MUL,
    ST_EMIT0, ST_P1MUL, ST_P1INT, ST_EMIT1, ST_LMUL, ST_LINT1, ST_LINT2, ST_LSUB,
    ST_LDIV, ST_LEMIT, ST_LSH0, ST_LSH1
  } state_t;

  // Sign and magnitude back to two's complement, saturating at the bounds.
  function automatic sm_res_t from_sm(input logic neg, input logic [63:0] mag);
    sm_res_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > VAL_MIN) begin
        r.sat   = 1'b1;
        r.value = VAL_MIN;
      end else begin
        r.value = 64'd0 - mag;
      end
    end else if (mag[63]) begin
      r.sat   = 1'b1;
      r.value = VAL_MAX;
    end else begin
      r.value = mag;
    end
    return r;
  endfunction

  // Divisor of Taylor term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
  function automatic logic [9:0] taylor_div(input logic [3:0] k, input logic is_cos);
    logic [9:0] a;
    logic [9:0] b;
    a = {5'd0, k, 1'b0};
    b = is_cos ? (a - 10'd1) : (a + 10'd1);
    return a * b;
  endfunction

endpackage

@@ design/alg_dp.sv @@
// ----------------------------------------------------------------------------
// alg_dp
// Fixed-point datapath: register set, a 32x32 multiplier summing four partial
// products, a bit-serial divider, small-integer scaling and saturating subtract.
// ----------------------------------------------------------------------------
module alg_dp
  import alg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [63:0] x_r, x2_r, t_r, sum_r, s_r, ns_r, c_r, p0_r, p1_r, a1_r, a2_r;
  logic [63:0] a_val, b_val, mag_a;

  logic         run_r;
  op_t          op_r;
  sel_t         dst_r;
  logic         track_r;
  logic         neg_r;
  logic [6:0]   cnt_r;
  logic [63:0]  mb_r;
  logic [127:0] acc_r;
  logic [63:0]  quo_r;
  logic [9:0]   rem_r;
  logic [9:0]   dvs_r;
  logic         ovf_r;
  logic         done_r;
  logic         out_strobe_r;
  out_item_t    out_item_r;

  logic         wr_en;
  sel_t         wr_dst;
  logic [63:0]  wr_val;
  logic         wr_sat;
  logic         wr_track;
  logic         single;
  logic         finish;

  logic [31:0]  mul_x, mul_y;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [10:0]  rem2;
  logic         qbit;
  logic [73:0]  prodk;
  logic [64:0]  diff;
  logic [63:0]  qmag;
  sm_res_t      sm;

  function automatic logic [63:0] rd(input sel_t s);
    logic [63:0] v;
    unique case (s)
      SEL_ZERO: v = '0;
      SEL_ONE:  v = ONE;
      SEL_X:    v = x_r;
      SEL_X2:   v = x2_r;
      SEL_T:    v = t_r;
      SEL_SUM:  v = sum_r;
      SEL_S:    v = s_r;
      SEL_NS:   v = ns_r;
      SEL_C:    v = c_r;
      SEL_P0:   v = p0_r;
      SEL_P1:   v = p1_r;
      SEL_A1:   v = a1_r;
      SEL_A2:   v = a2_r;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign a_val = rd(cmd.src_a);
  assign b_val = rd(cmd.src_b);
  assign mag_a = a_val[63] ? (64'd0 - a_val) : a_val;

  // Partial products of the multiplier, one per cycle.
  always_comb begin
    mul_x = cnt_r[0] ? quo_r[63:32] : quo_r[31:0];
    mul_y = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp    = 64'(mul_x) * 64'(mul_y);
    unique case (cnt_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // One quotient bit per cycle.
  always_comb begin
    rem2 = {rem_r, quo_r[63]};
    qbit = (rem2 >= {1'b0, dvs_r});
  end

  always_comb begin
    prodk = 74'(mag_a) * 74'(cmd.k);
    diff  = {a_val[63], a_val} - {b_val[63], b_val};
  end

  always_comb begin
    single   = cmd.go && (cmd.op != OP_MULQ) && (cmd.op != OP_DIV);
    finish   = run_r && (((op_r == OP_MULQ) && (cnt_r == 7'd4)) ||
                         ((op_r == OP_DIV) && (cnt_r == 7'd64)));
    wr_en    = 1'b0;
    wr_dst   = cmd.dst;
    wr_val   = a_val;
    wr_sat   = 1'b0;
    wr_track = cmd.track;
    qmag     = '0;
    sm       = '0;
    if (finish) begin
      wr_en    = 1'b1;
      wr_dst   = dst_r;
      wr_track = track_r;
      if (op_r == OP_MULQ) begin
        qmag = (acc_r[127:64+FRAC_BITS] != '0) ? '1 : acc_r[63+FRAC_BITS:FRAC_BITS];
      end else begin
        qmag = quo_r;
      end
      sm     = from_sm(neg_r, qmag);
      wr_val = sm.value;
      wr_sat = sm.sat;
    end else if (single) begin
      unique case (cmd.op)
        OP_MOV: begin
          wr_en = 1'b1;
        end
        OP_LDANG: begin
          wr_en  = 1'b1;
          wr_val = 64'(ANGLE_K * 64'(cmd.k));
        end
        OP_CLAMP: begin
          wr_en = 1'b1;
          if (a_val[63]) begin
            wr_val = '0;
          end else if (a_val > ONE) begin
            wr_val = ONE;
          end
        end
        OP_SUB: begin
          wr_en = 1'b1;
          if (diff[64] != diff[63]) begin
            wr_sat = 1'b1;
            wr_val = diff[64] ? VAL_MIN : VAL_MAX;
          end else begin
            wr_val = diff[63:0];
          end
        end
        OP_MULI: begin
          wr_en  = 1'b1;
          sm     = from_sm(a_val[63], (prodk[73:64] != '0) ? '1 : prodk[63:0]);
          wr_val = sm.value;
          wr_sat = sm.sat | (prodk[73:64] != '0);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_dst)
        SEL_X:   x_r   <= wr_val;
        SEL_X2:  x2_r  <= wr_val;
        SEL_T:   t_r   <= wr_val;
        SEL_SUM: sum_r <= wr_val;
        SEL_S:   s_r   <= wr_val;
        SEL_NS:  ns_r  <= wr_val;
        SEL_C:   c_r   <= wr_val;
        SEL_P0:  p0_r  <= wr_val;
        SEL_P1:  p1_r  <= wr_val;
        SEL_A1:  a1_r  <= wr_val;
        SEL_A2:  a2_r  <= wr_val;
        default: ;
      endcase
    end
    if (cmd.go && (cmd.op == OP_MULQ)) begin
      quo_r   <= mag_a;
      mb_r    <= b_val[63] ? (64'd0 - b_val) : b_val;
      neg_r   <= a_val[63] ^ b_val[63];
      acc_r   <= '0;
      op_r    <= cmd.op;
      dst_r   <= cmd.dst;
      track_r <= cmd.track;
    end else if (cmd.go && (cmd.op == OP_DIV)) begin
      quo_r   <= mag_a;
      rem_r   <= '0;
      dvs_r   <= cmd.k;
      neg_r   <= a_val[63];
      op_r    <= cmd.op;
      dst_r   <= cmd.dst;
      track_r <= cmd.track;
    end else if (run_r && !finish) begin
      if (op_r == OP_MULQ) begin
        acc_r <= acc_r + pp_sh;
      end else begin
        rem_r <= qbit ? 10'(rem2 - {1'b0, dvs_r}) : rem2[9:0];
        quo_r <= {quo_r[62:0], qbit};
      end
    end
    if (single && (cmd.op == OP_EMIT)) begin
      out_item_r.degree      <= cmd.degree;
      out_item_r.value       <= a_val;
      out_item_r.last        <= cmd.last;
      out_item_r.overflow    <= cmd.bad ? 1'b0 : ovf_r;
      out_item_r.bad_request <= cmd.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      done_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      done_r       <= single || finish;
      out_strobe_r <= single && (cmd.op == OP_EMIT);
      if (cmd.go && ((cmd.op == OP_MULQ) || (cmd.op == OP_DIV))) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (finish) begin
        run_r <= 1'b0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 7'd1;
      end
      if (single && (cmd.op == OP_CLR)) begin
        ovf_r <= 1'b0;
      end else if (wr_en && wr_track && wr_sat) begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign stat.done  = done_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ design/alg_ctrl.sv @@
// ----------------------------------------------------------------------------
// alg_ctrl
// Sequencer: angle, sine and cosine series, then the degree recurrence,
// issued to the datapath one operation at a time. Holds point_count.
// ----------------------------------------------------------------------------
module alg_ctrl
  import alg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data,
  output dp_cmd_t   cmd,
  input  dp_stat_t  stat
);

  state_t     state_r, state_nxt;
  logic       issued_r, issued_nxt;
  logic [5:0] m_r, m_nxt;
  logic [5:0] j_r, j_nxt;
  logic [5:0] lmax_r, lmax_nxt;
  logic [6:0] l_r, l_nxt;
  logic [3:0] kt_r, kt_nxt;
  logic       cos_r, cos_nxt;
  logic [5:0] i_r, i_nxt;
  logic [6:0] pc_r;
  logic [6:0] n_eff;
  logic [5:0] lmax_in;
  logic [6:0] m_ext;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign m_ext     = {1'b0, m_r};

  always_comb begin
    if (pc_r < 7'd2) begin
      n_eff = 7'd2;
    end else if (pc_r > 7'(MAX_POINTS)) begin
      n_eff = 7'(MAX_POINTS);
    end else begin
      n_eff = pc_r;
    end
    lmax_in = 6'(n_eff - 7'd1);
  end

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    m_nxt      = m_r;
    j_nxt      = j_r;
    lmax_nxt   = lmax_r;
    l_nxt      = l_r;
    kt_nxt     = kt_r;
    cos_nxt    = cos_r;
    i_nxt      = i_r;
    if (state_r == ST_IDLE) begin
      if (start) begin
        m_nxt    = in_item.order_m;
        j_nxt    = in_item.grid_point;
        lmax_nxt = lmax_in;
        kt_nxt   = 4'd1;
        cos_nxt  = 1'b0;
        state_nxt = ((in_item.order_m > lmax_in) || (in_item.grid_point > lmax_in)) ?
                    ST_BAD : ST_CLR;
      end
    end else if (!issued_r) begin
      issued_nxt = 1'b1;
    end else if (stat.done) begin
      issued_nxt = 1'b0;
      unique case (state_r)
        ST_BAD:     state_nxt = ST_IDLE;
        ST_CLR:     state_nxt = ST_ANG_MUL;
        ST_ANG_MUL: state_nxt = ST_ANG_DIV;
        ST_ANG_DIV: state_nxt = ST_X2;
        ST_X2:      state_nxt = ST_TINIT;
        ST_TINIT:   state_nxt = ST_SINIT;
        ST_SINIT:   state_nxt = ST_TMUL;
        ST_TMUL:    state_nxt = ST_TDIV;
        ST_TDIV:    state_nxt = ST_TNEG;
        ST_TNEG:    state_nxt = ST_TSUM;
        ST_TSUM: begin
          if (kt_r == 4'(TAYLOR_TERMS)) begin
            state_nxt = ST_TCLAMP;
          end else begin
            kt_nxt    = kt_r + 4'd1;
            state_nxt = ST_TMUL;
          end
        end
        ST_TCLAMP: begin
          kt_nxt = 4'd1;
          if (cos_r) begin
            state_nxt = ST_NEG;
          end else begin
            cos_nxt   = 1'b1;
            state_nxt = ST_TINIT;
          end
        end
        ST_NEG:     state_nxt = ST_P0INIT;
        ST_P0INIT: begin
          i_nxt     = '0;
          state_nxt = (m_r == 6'd0) ? ST_EMIT0 : ST_P0MUL;
        end
        ST_P0MUL: begin
          i_nxt     = i_r + 6'd1;
          state_nxt = ((i_r + 6'd1) == m_r) ? ST_EMIT0 : ST_P0MUL;
        end
        ST_EMIT0:   state_nxt = (m_r == lmax_r) ? ST_IDLE : ST_P1MUL;
        ST_P1MUL:   state_nxt = ST_P1INT;
        ST_P1INT:   state_nxt = ST_EMIT1;
        ST_EMIT1: begin
          l_nxt     = m_ext + 7'd2;
          state_nxt = ((m_ext + 7'd1) == {1'b0, lmax_r}) ? ST_IDLE : ST_LMUL;
        end
        ST_LMUL:    state_nxt = ST_LINT1;
        ST_LINT1:   state_nxt = ST_LINT2;
        ST_LINT2:   state_nxt = ST_LSUB;
        ST_LSUB:    state_nxt = ST_LDIV;
        ST_LDIV:    state_nxt = ST_LEMIT;
        ST_LEMIT:   state_nxt = (l_r == {1'b0, lmax_r}) ? ST_IDLE : ST_LSH0;
        ST_LSH0:    state_nxt = ST_LSH1;
        ST_LSH1: begin
          l_nxt     = l_r + 7'd1;
          state_nxt = ST_LMUL;
        end
        default:    state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_MOV;
    cmd.src_a  = SEL_ZERO;
    cmd.src_b  = SEL_ZERO;
    cmd.dst    = SEL_A1;
    cmd.go     = (state_r != ST_IDLE) && !issued_r;
    cmd.degree = l_r[5:0];
    unique case (state_r)
      ST_IDLE: cmd.go = 1'b0;
      ST_BAD: begin
        cmd.op     = OP_EMIT;
        cmd.degree = '0;
        cmd.last   = 1'b1;
        cmd.bad    = 1'b1;
      end
      ST_CLR:     cmd.op = OP_CLR;
      ST_ANG_MUL: begin
        cmd.op  = OP_LDANG;
        cmd.dst = SEL_X;
        cmd.k   = 10'(j_r);
      end
      ST_ANG_DIV: begin
        cmd.op    = OP_DIV;
        cmd.src_a = SEL_X;
        cmd.dst   = SEL_X;
        cmd.k     = 10'(lmax_r);
      end
      ST_X2: begin
        cmd.op    = OP_MULQ;
        cmd.src_a = SEL_X;
        cmd.src_b = SEL_X;
        cmd.dst   = SEL_X2;
      end
      ST_TINIT: begin
        cmd.src_a = cos_r ? SEL_ONE : SEL_X;
        cmd.dst   = SEL_T;
      end
      ST_SINIT: begin
        cmd.src_a = cos_r ? SEL_ONE : SEL_X;
        cmd.dst   = SEL_SUM;
      end
      ST_TMUL: begin
        cmd.op    = OP_MULQ;
        cmd.src_a = SEL_T;
        cmd.src_b = SEL_X2;
      end
      ST_TDIV: begin
        cmd.op    = OP_DIV;
        cmd.src_a = SEL_A1;
        cmd.k     = taylor_div(kt_r, cos_r);
      end
      ST_TNEG: begin
        cmd.op    = OP_SUB;
        cmd.src_b = SEL_A1;
        cmd.dst   = SEL_T;
      end
      ST_TSUM: begin
        cmd.op    = OP_SUB;
        cmd.src_a = SEL_SUM;
        cmd.src_b = SEL_A1;
        cmd.dst   = SEL_SUM;
      end
      ST_TCLAMP: begin
        cmd.op    = OP_CLAMP;
        cmd.src_a = SEL_SUM;
        cmd.dst   = cos_r ? SEL_C : SEL_S;
      end
      ST_NEG: begin
        cmd.op    = OP_SUB;
        cmd.src_b = SEL_S;
        cmd.dst   = SEL_NS;
      end
      ST_P0INIT: begin
        cmd.src_a = SEL_ONE;
        cmd.dst   = SEL_P0;
      end
      ST_P0MUL: begin
        cmd.op    = OP_MULQ;
        cmd.src_a = SEL_P0;
        cmd.src_b = SEL_NS;
        cmd.dst   = SEL_P0;
        cmd.track = 1'b1;
      end
      ST_EMIT0: begin
        cmd.op     = OP_EMIT;
        cmd.src_a  = SEL_P0;
        cmd.degree = m_r;
        cmd.last   = (m_r == lmax_r);
      end
      ST_P1MUL: begin
        cmd.op    = OP_MULQ;
        cmd.src_a = SEL_C;
        cmd.src_b = SEL_P0;
        cmd.track = 1'b1;
      end
      ST_P1INT: begin
        cmd.op    = OP_MULI;
        cmd.src_a = SEL_A1;
        cmd.dst   = SEL_P1;
        cmd.k     = 10'({m_r, 1'b1});
        cmd.track = 1'b1;
      end
      ST_EMIT1: begin
        cmd.op     = OP_EMIT;
        cmd.src_a  = SEL_P1;
        cmd.degree = m_r + 6'd1;
        cmd.last   = ((m_ext + 7'd1) == {1'b0, lmax_r});
      end
      ST_LMUL: begin
        cmd.op    = OP_MULQ;
        cmd.src_a = SEL_C;
        cmd.src_b = SEL_P1;
        cmd.track = 1'b1;
      end
      ST_LINT1: begin
        cmd.op    = OP_MULI;
        cmd.src_a = SEL_A1;
        cmd.k     = 10'({l_r, 1'b0} - 8'd1);
        cmd.track = 1'b1;
      end
      ST_LINT2: begin
        cmd.op    = OP_MULI;
        cmd.src_a = SEL_P0;
        cmd.dst   = SEL_A2;
        cmd.k     = 10'(l_r + m_ext - 7'd1);
        cmd.track = 1'b1;
      end
      ST_LSUB: begin
        cmd.op    = OP_SUB;
        cmd.src_a = SEL_A1;
        cmd.src_b = SEL_A2;
        cmd.track = 1'b1;
      end
      ST_LDIV: begin
        cmd.op    = OP_DIV;
        cmd.src_a = SEL_A1;
        cmd.k     = 10'(l_r - m_ext);
        cmd.track = 1'b1;
      end
      ST_LEMIT: begin
        cmd.op    = OP_EMIT;
        cmd.src_a = SEL_A1;
        cmd.last  = (l_r == {1'b0, lmax_r});
      end
      ST_LSH0: begin
        cmd.src_a = SEL_P1;
        cmd.dst   = SEL_P0;
      end
      ST_LSH1: begin
        cmd.src_a = SEL_A1;
        cmd.dst   = SEL_P1;
      end
      default: cmd.go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
      pc_r     <= 7'd64;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      if (cfg_valid && cfg_ready) begin
        pc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    j_r    <= j_nxt;
    lmax_r <= lmax_nxt;
    l_r    <= l_nxt;
    kt_r   <= kt_nxt;
    cos_r  <= cos_nxt;
    i_r    <= i_nxt;
  end

endmodule

@@ design/assoc_legendre_grid_recurrence_unit.sv @@
// ----------------------------------------------------------------------------
// assoc_legendre_grid_recurrence_unit
// Associated Legendre values P_l^m(cos theta)/(2m-1)!! on a uniform grid.
//
//   channel  ports                      beat taken when
//   in       start, busy, in_item       start high, busy low
//   out      out_strobe, out_item       out_strobe high (one cycle)
//   cfg      cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// Operations go through the datapath one at a time: moves, subtracts and small
// scalings, 64-bit products built from four 32x32 partial products, and
// divisions that yield one quotient bit per cycle. Sine and cosine come first,
// then degrees m up to N - 1. A bad request gives a single beat with degree 0,
// last and bad_request set. Reset is synchronous; the receiver cannot stall.
// ----------------------------------------------------------------------------
module assoc_legendre_grid_recurrence_unit
  import alg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  alg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  alg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the associated Legendre grid recurrence unit.
// A table of directed requests is followed by random phases, each with its own
// point count. Every accepted request but the typed-in bad-request rows is
// expanded into the expected series of degrees by a fixed-point predictor,
// and each output beat is checked against it.
// ----------------------------------------------------------------------------
module tb
  import alg_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int RANDOM_ITEMS   = 400;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_data;

  assoc_legendre_grid_recurrence_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  out_item_t   degree_q[$];
  logic [6:0]  point_count_reg;
  int          errors;
  int          req_beats;
  int          cfg_beats;
  int          idle_cycles;
  bit          force_bad_row;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic longint from_mag(input bit neg, input logic [63:0] mag,
                                      inout bit ovf);
    if (neg) begin
      if (mag > VAL_MIN) begin
        ovf = 1'b1;
        return longint'(VAL_MIN);
      end
      return longint'(64'd0 - mag);
    end
    if (mag[63]) begin
      ovf = 1'b1;
      return longint'(VAL_MAX);
    end
    return longint'(mag);
  endfunction

  function automatic logic [63:0] mag_of(input longint v);
    return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, inout bit ovf);
    logic [127:0] p;
    logic [63:0]  mag;
    p = 128'(mag_of(a)) * 128'(mag_of(b));
    if ((p >> (64 + FRAC_BITS)) != 0) mag = '1;
    else mag = 64'(p >> FRAC_BITS);
    return from_mag((a < 0) != (b < 0), mag, ovf);
  endfunction

  function automatic longint int_mul(input longint v, input logic [63:0] k, inout bit ovf);
    logic [127:0] p;
    logic [63:0]  mag;
    p = 128'(mag_of(v)) * 128'(k);
    mag = (p[127:64] != 0) ? '1 : p[63:0];
    return from_mag(v < 0, mag, ovf);
  endfunction

  function automatic longint int_div(input longint v, input logic [63:0] d, inout bit ovf);
    if (d == 0) return v;
    return from_mag(v < 0, mag_of(v) / d, ovf);
  endfunction

  function automatic longint clip_sub(input longint a, input longint b, inout bit ovf);
    logic [64:0] r;
    r = {a[63], 64'(a)} - {b[63], 64'(b)};
    if (r[64] != r[63]) begin
      ovf = 1'b1;
      return r[64] ? longint'(VAL_MIN) : longint'(VAL_MAX);
    end
    return longint'(r[63:0]);
  endfunction

  function automatic longint series_sum(input longint x, input bit is_sine);
    bit          junk;
    longint      x2, term, sum;
    logic [63:0] d;
    junk = 1'b0;
    x2   = fx_mul(x, x, junk);
    term = is_sine ? x : longint'(ONE);
    sum  = term;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      d    = is_sine ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
      term = fx_mul(term, x2, junk);
      term = int_div(term, d, junk);
      term = clip_sub(0, term, junk);
      sum  = clip_sub(sum, clip_sub(0, term, junk), junk);
    end
    if (sum < 0) return 0;
    if (sum > longint'(ONE)) return longint'(ONE);
    return sum;
  endfunction

  function automatic int eff_points(input logic [6:0] pc);
    if (pc < 2) return 2;
    if (pc > MAX_POINTS) return MAX_POINTS;
    return int'(pc);
  endfunction

  function automatic out_item_t make_beat(input int l, input longint v, input bit last,
                                          input bit ovf, input bit bad);
    out_item_t b;
    b.degree      = 6'(l);
    b.value       = v;
    b.last        = last;
    b.overflow    = ovf;
    b.bad_request = bad;
    return b;
  endfunction

  // Expected degree series for one request under the current point count.
  task automatic predict_series(input in_item_t req);
    int          m, j, lmax;
    longint      x, s, c, p0, p1, p2, t1, t2;
    bit          ovf;
    m    = int'(req.order_m);
    j    = int'(req.grid_point);
    lmax = eff_points(point_count_reg) - 1;
    ovf  = 1'b0;
    if (m > lmax || j > lmax) begin
      degree_q.push_back(make_beat(0, 0, 1'b1, 1'b0, 1'b1));
      return;
    end
    x  = longint'((ANGLE_K * 64'(j)) / 64'(lmax));
    s  = series_sum(x, 1'b1);
    c  = series_sum(x, 1'b0);
    p0 = longint'(ONE);
    for (int i = 0; i < m; i++) p0 = fx_mul(p0, -s, ovf);
    degree_q.push_back(make_beat(m, p0, m == lmax, ovf, 1'b0));
    if (m == lmax) return;
    p1 = int_mul(fx_mul(c, p0, ovf), 64'(2 * m + 1), ovf);
    degree_q.push_back(make_beat(m + 1, p1, m + 1 == lmax, ovf, 1'b0));
    for (int l = m + 2; l <= lmax; l++) begin
      t1 = int_mul(fx_mul(c, p1, ovf), 64'(2 * l - 1), ovf);
      t2 = int_mul(p0, 64'(l + m - 1), ovf);
      p2 = int_div(clip_sub(t1, t2, ovf), 64'(l - m), ovf);
      degree_q.push_back(make_beat(l, p2, l == lmax, ovf, 1'b0));
      p0 = p1;
      p1 = p2;
    end
  endtask

  // ---------------- monitor and scoreboard ----------------
  always @(posedge clk) begin
    out_item_t want;
    bit        hit;
    hit = 1'b0;
    if (!rst_n) begin
      point_count_reg <= 7'd64;
    end else begin
      if (cfg_valid && cfg_ready) begin
        point_count_reg <= cfg_data;
        cfg_beats++;
        hit = 1'b1;
      end
      if (start && !busy) begin
        // Bad-request rows carry their result typed in; the rest are predicted.
        if (force_bad_row) degree_q.push_back(make_beat(0, 0, 1'b1, 1'b0, 1'b1));
        else predict_series(in_item);
        req_beats++;
        hit = 1'b1;
      end
      if (out_strobe) begin
        hit = 1'b1;
        if (degree_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: %p", out_item);
        end else begin
          want = degree_q.pop_front();
          if (out_item.degree !== want.degree || out_item.value !== want.value ||
              out_item.last !== want.last || out_item.overflow !== want.overflow ||
              out_item.bad_request !== want.bad_request) begin
            errors++;
            if (errors <= 10)
              $display("beat mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
    end
    idle_cycles = hit ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  typedef struct {
    logic [6:0] pc;
    logic [5:0] m;
    logic [5:0] j;
    bit         bad;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{7'd64, 6'd0, 6'd0, 1'b0}, '{7'd64, 6'd63, 6'd63, 1'b0},
    '{7'd64, 6'd0, 6'd63, 1'b0}, '{7'd64, 6'd63, 6'd0, 1'b0},
    '{7'd64, 6'd1, 6'd32, 1'b0}, '{7'd64, 6'd42, 6'd21, 1'b0},
    '{7'd0, 6'd0, 6'd0, 1'b0}, '{7'd0, 6'd1, 6'd1, 1'b0},
    '{7'd0, 6'd2, 6'd0, 1'b1}, '{7'd0, 6'd0, 6'd63, 1'b1},
    '{7'd0, 6'd63, 6'd63, 1'b1}, '{7'd1, 6'd1, 6'd0, 1'b0},
    '{7'd2, 6'd0, 6'd1, 1'b0}, '{7'd127, 6'd5, 6'd10, 1'b0},
    '{7'd127, 6'd0, 6'd42, 1'b0}, '{7'd8, 6'd7, 6'd7, 1'b0},
    '{7'd8, 6'd8, 6'd3, 1'b1}, '{7'd8, 6'd3, 6'd8, 1'b1},
    '{7'd8, 6'd0, 6'd4, 1'b0}, '{7'd65, 6'd21, 6'd42, 1'b0}
  };

  logic [6:0] drv_pc;

  // Waits until every expected beat is in and the block has gone idle.
  task automatic drain;
    while (degree_q.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_points(input logic [6:0] v);
    int n;
    drain();
    n = cfg_beats;
    cfg_data  = v;
    cfg_valid = 1'b1;
    while (cfg_beats == n) @(negedge clk);
    cfg_valid = 1'b0;
    drv_pc = v;
  endtask

  task automatic send_req(input logic [5:0] m, input logic [5:0] j, input bit bad,
                          input int gap);
    int n;
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    n = req_beats;
    in_item.order_m    = m;
    in_item.grid_point = j;
    force_bad_row      = bad;
    start              = 1'b1;
    while (req_beats == n) @(negedge clk);
    start         = 1'b0;
    force_bad_row = 1'b0;
  endtask

  initial begin
    int  sent, n_pts, n_items, sel;
    bit  no_gaps;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    force_bad_row = 1'b0;
    errors = 0;
    req_beats = 0;
    cfg_beats = 0;
    idle_cycles = 0;
    drv_pc = 7'd64;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].pc != drv_pc) write_points(dir_rows[i].pc);
      send_req(dir_rows[i].m, dir_rows[i].j, dir_rows[i].bad, $urandom_range(0, 13));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) write_points(7'd64);
      else if (sel == 1) write_points(7'($urandom_range(0, 127)));
      else write_points(7'($urandom_range(2, 16)));
      n_pts   = eff_points(drv_pc);
      n_items = (n_pts > 16) ? $urandom_range(4, 10) : $urandom_range(15, 40);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 6) == 0)
          send_req(6'($urandom()), 6'($urandom()), 1'b0,
                   no_gaps ? 0 : $urandom_range(0, 13));
        else
          send_req(6'($urandom_range(0, n_pts - 1)), 6'($urandom_range(0, n_pts - 1)),
                   1'b0, no_gaps ? 0 : $urandom_range(0, 13));
        sent++;
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (degree_q.size() != 0) errors++;
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
design/alg_pkg.sv
design/alg_dp.sv
design/alg_ctrl.sv
design/assoc_legendre_grid_recurrence_unit.sv
sim/tb.sv
